// ===== hdl/ppcc_pkg.sv =====
`timescale 1ns / 1ps

package ppcc_pkg;

  localparam int PORT_W    = 16;
  localparam int KEY_W     = 32;
  localparam int LEN_W     = 3;
  localparam int BKT_W     = 2;
  localparam int OP_W      = 2;
  localparam int ENTRY_W   = 3;
  localparam int PT_DEPTH  = 65536;
  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd0;
  localparam logic [OP_W-1:0] OP_PORT_WR  = 2'd1;
  localparam logic [OP_W-1:0] OP_RULE_ADD = 2'd2;

  localparam logic [BKT_W-1:0] BKT_EASY = 2'd0;
  localparam logic [BKT_W-1:0] BKT_HARD = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_CHAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [LEN_W-1:0]  len;
    logic [KEY_W-1:0]  bytes;
    logic [BKT_W-1:0]  bkt;
  } rule_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  klen;
  } query_t;

  typedef struct packed {
    logic              vld;
    logic [LEN_W-1:0]  len;
    logic [BKT_W-1:0]  bkt;
  } tok_t;

  typedef struct packed {
    logic              status;
    logic [BKT_W-1:0]  bkt;
  } res_t;

  function automatic logic [KEY_W-1:0] lead_mask(input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    unique case (len)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'hFF00_0000;
      3'd2:    m = 32'hFFFF_0000;
      3'd3:    m = 32'hFFFF_FF00;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [BKT_W-1:0] clamp_bkt(input logic [BKT_W-1:0] b);
    return (b > BKT_HARD) ? BKT_HARD : b;
  endfunction

endpackage

// ===== hdl/port_prefix_cost_classifier_unit.sv =====
`timescale 1ns / 1ps
// A port write, rule append or unused operation goes straight to the done state. A lookup
// reads the port table and finishes on a valid port entry; otherwise it injects a query
// token that walks the rule cell chain one cell per cycle and finishes when it leaves the chain.
// One word is in flight at a time; the next is taken once the result is registered.
// Reset clears the rule count and then sweeps the 65536-entry port table, one entry
// per cycle, with in_tready low until the sweep ends.

module port_prefix_cost_classifier_unit
  import ppcc_pkg::*;
#(
  parameter int MAX_RULES        = 64,
  parameter int MAX_PREFIX_BYTES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // port[15:0], key_bytes[47:16], key_length[50:48], bucket_in[52:51], zero[55:53]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // bucket_out[1:0], status[2], zero[7:3]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int PT_AW = $clog2(PT_DEPTH);

  state_t state_r, state_nxt;
  logic [PT_AW-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  query_t q_r;
  res_t   res_r, res_nxt;
  logic   out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic                  in_acc;
  logic [PORT_W-1:0]     in_port;
  logic [KEY_W-1:0]      in_key;
  logic [LEN_W-1:0]      in_klen;
  logic [BKT_W-1:0]      in_bkt;
  logic                  ram_we;
  logic [PT_AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic                  inject;
  logic                  rule_we;
  logic                  out_load;
  rule_t                 new_rule;
  tok_t                  tok [MAX_RULES+1];

  assign in_port  = in_tdata[15:0];
  assign in_key   = in_tdata[47:16];
  assign in_klen  = in_tdata[50:48];
  assign in_bkt   = in_tdata[52:51];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign new_rule.port  = in_port;
  assign new_rule.len   = in_klen;
  assign new_rule.bytes = in_key & lead_mask(in_klen);
  assign new_rule.bkt   = clamp_bkt(in_bkt);

  ppcc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PT_DEPTH)
  ) u_port_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_port),
    .rdata (ram_rdata)
  );

  always_comb begin
    tok[0].vld = inject;
    tok[0].len = '0;
    tok[0].bkt = BKT_HARD;
  end

  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    ppcc_cell #(
      .MAX_PREFIX_BYTES (MAX_PREFIX_BYTES)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .active  (CNT_W'(i) < cnt_r),
      .wr_en   (rule_we && (cnt_r == CNT_W'(i))),
      .wr_rule (new_rule),
      .q       (q_r),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    inject    = 1'b0;
    rule_we   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt   = '0;
          state_nxt = ST_DONE;
          unique case (in_tuser)
            OP_LOOKUP: begin
              state_nxt = ST_LOOK;
            end
            OP_PORT_WR: begin
              ram_we    = 1'b1;
              ram_waddr = in_port;
              ram_wdata = {1'b1, clamp_bkt(in_bkt)};
            end
            OP_RULE_ADD: begin
              if (cnt_r == CNT_W'(MAX_RULES)) begin
                res_nxt.status = 1'b1;
              end else begin
                rule_we = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            default: begin
              res_nxt = '0;
            end
          endcase
        end
      end
      ST_LOOK: begin
        if (ram_rdata[ENTRY_W-1]) begin
          res_nxt.bkt = ram_rdata[BKT_W-1:0];
          state_nxt   = ST_DONE;
        end else begin
          inject    = 1'b1;
          state_nxt = ST_CHAIN;
        end
      end
      ST_CHAIN: begin
        if (tok[MAX_RULES].vld) begin
          res_nxt.bkt = tok[MAX_RULES].bkt;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_acc) begin
      q_r.port <= in_port;
      q_r.key  <= in_key;
      q_r.klen <= in_klen;
    end
    if (out_load) begin
      out_tdata_r <= {{(OUT_DATA_W-BKT_W-1){1'b0}}, res_r.status, res_r.bkt};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RULES))
    else $error("rule count beyond capacity");

  a_tok_only_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    tok[MAX_RULES].vld |-> state_r == ST_CHAIN)
    else $error("query token left the chain outside a lookup");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside the done state");

endmodule

// ===== hdl/ppcc_ram.sv =====
`timescale 1ns / 1ps

module ppcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ppcc_cell.sv =====
`timescale 1ns / 1ps

module ppcc_cell
  import ppcc_pkg::*;
#(
  parameter int MAX_PREFIX_BYTES = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   active,
  input  logic   wr_en,
  input  rule_t  wr_rule,
  input  query_t q,
  input  tok_t   tok_in,
  output tok_t   tok_out
);

  rule_t rule_r;
  tok_t  tok_r;
  tok_t  tok_nxt;
  logic  hit;

  always_comb begin
    hit = active
        && (rule_r.port == q.port)
        && (rule_r.len != '0)
        && (rule_r.len <= LEN_W'(MAX_PREFIX_BYTES))
        && (rule_r.len <= q.klen)
        && ((q.key & lead_mask(rule_r.len)) == rule_r.bytes);
    tok_nxt = tok_in;
    if (tok_in.vld && hit && (tok_in.len == '0 || rule_r.len < tok_in.len)) begin
      tok_nxt.len = rule_r.len;
      tok_nxt.bkt = rule_r.bkt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_r <= wr_rule;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
